// ===== hdl/cmfd_pkg.sv =====
package cmfd_pkg;

   // Routing targets
   typedef enum logic [2:0] {
      TGT_NONE       = 3'd0,
      TGT_FRICTION_A = 3'd1,
      TGT_FRICTION_B = 3'd2,
      TGT_FEEDER     = 3'd3,
      TGT_PITCH      = 3'd4,
      TGT_YAW        = 3'd5,
      TGT_CHASSIS    = 3'd6
   } target_type;

   localparam int NUM_TARGETS = 6;

   // Standard identifiers
   localparam logic [10:0] ID_FRICTION_A = 11'h201;
   localparam logic [10:0] ID_FRICTION_B = 11'h202;
   localparam logic [10:0] ID_FEEDER     = 11'h203;
   localparam logic [10:0] ID_PITCH      = 11'h206;
   localparam logic [10:0] ID_YAW        = 11'h208;
   localparam logic [10:0] ID_CHASSIS    = 11'h0BB;

   localparam logic       BUS_FIRST  = 1'b0;

   // Rotor jump beyond this marks a wrap
   localparam logic signed [16:0] WRAP_LIMIT = 17'sd4096;

   typedef struct packed {
      logic        bus;
      logic [10:0] frame_id;
      logic [63:0] payload;
   } req_type;

   typedef struct packed {
      logic [2:0]         target;
      logic [15:0]        rotor_position;
      logic signed [15:0] speed;
      logic signed [15:0] torque_current;
      logic [7:0]         temperature;
      logic [12:0]        shaft_position;
      logic [39:0]        status_bytes;
      logic [15:0]        frame_count;
   } rsp_type;

   // Classified frame as held in the queue
   typedef struct packed {
      target_type  target;
      logic [63:0] payload;
   } job_type;

endpackage

// ===== hdl/can_motor_feedback_decoder.sv =====
// Path: an accepted request is held in the queue, then passes the decode/state stage
//   and the reciprocal-multiply stage before it reaches the result ports.
// Throughput: one request per cycle without stalls; the turn tracker and counters close in one stage.
// Result side stalls: the 4-entry queue plus the two stage registers hold 6 requests
//   before full rises.
// Reset: synchronous, active high; clears queue, pipeline valids, frame counters
//   and feeder reference state. No clearing pass.
module can_motor_feedback_decoder
   import cmfd_pkg::*;
#(
   parameter int GEAR_TURNS = 36
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   // front -> queue
   logic    q_write;
   job_type q_wr_job;
   // queue -> back
   logic    q_full;
   logic    q_empty;
   logic    q_read;
   job_type q_rd_job;

   // Front: classify each request by bus and identifier
   cmfd_front u_front (
      .req_push (req_push),
      .req_data (req_data),
      .q_full   (q_full),
      .q_write  (q_write),
      .q_job    (q_wr_job)
   );

   // Decoupling queue, full is the input back-pressure
   cmfd_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (q_write),
      .wr_job (q_wr_job),
      .full   (q_full),
      .rd_en  (q_read),
      .rd_job (q_rd_job),
      .empty  (q_empty)
   );

   // Back: counters, feeder angle, output register
   cmfd_back #(
      .GEAR_TURNS (GEAR_TURNS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_job     (q_rd_job),
      .q_empty   (q_empty),
      .q_read    (q_read),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   assign req_full = q_full;

endmodule

// ===== hdl/cmfd_front.sv =====
module cmfd_front
   import cmfd_pkg::*;
(
   input  logic    req_push,
   input  req_type req_data,
   input  logic    q_full,
   output logic    q_write,
   output job_type q_job
);

   target_type target;

   // bus/ID routing
   always_comb begin
      target = TGT_NONE;
      if (req_data.bus == BUS_FIRST) begin
         unique case (req_data.frame_id)
            ID_FRICTION_A: target = TGT_FRICTION_A;
            ID_FRICTION_B: target = TGT_FRICTION_B;
            ID_FEEDER:     target = TGT_FEEDER;
            ID_PITCH:      target = TGT_PITCH;
            default:       target = TGT_NONE;
         endcase
      end else begin
         unique case (req_data.frame_id)
            ID_YAW:     target = TGT_YAW;
            ID_CHASSIS: target = TGT_CHASSIS;
            default:    target = TGT_NONE;
         endcase
      end
   end

   assign q_job.target  = target;
   assign q_job.payload = req_data.payload;
   assign q_write       = req_push && !q_full;

endmodule

// ===== hdl/cmfd_queue.sv =====
module cmfd_queue
   import cmfd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  job_type wr_job,
   output logic    full,
   input  logic    rd_en,
   output job_type rd_job,
   output logic    empty
);

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);

   job_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     count_ff, count_in;

   assign full   = (count_ff == (PTR_W+1)'(DEPTH));
   assign empty  = (count_ff == '0);
   assign rd_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(wr_en);
      rd_ptr_in = rd_ptr_ff + PTR_W'(rd_en);
      count_in  = count_ff + (PTR_W+1)'(wr_en) - (PTR_W+1)'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= wr_job;
      end
   end

`ifndef SYNTH
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> !empty)
      else $error("queue read while empty");
`endif

endmodule

// ===== hdl/cmfd_back.sv =====
module cmfd_back
   import cmfd_pkg::*;
#(
   parameter int GEAR_TURNS = 36
)
(
   input  logic    clock,
   input  logic    reset,
   input  job_type q_job,
   input  logic    q_empty,
   output logic    q_read,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   localparam int           SHIFT     = 26;
   localparam longint       RECIP     = ((64'd1 << SHIFT) + GEAR_TURNS - 1) / GEAR_TURNS;
   localparam logic [SHIFT-1:0] RECIP_C = RECIP[SHIFT-1:0];
   localparam logic [5:0]   LAST_TURN = 6'(GEAR_TURNS - 1);
   localparam logic [6:0]   GEAR_C    = 7'(GEAR_TURNS);
   localparam int           IDX_W     = $clog2(NUM_TARGETS);

   typedef struct packed {
      logic [2:0]         target;
      logic               feeder;
      logic [15:0]        rotor_position;
      logic signed [15:0] speed;
      logic signed [15:0] torque_current;
      logic [7:0]         temperature;
      logic [39:0]        status_bytes;
      logic [15:0]        frame_count;
      logic [5:0]         turn_mod;
      logic [6:0]         fine;
   } stage_type;

   // (k - 8) mod GEAR_TURNS for the coarse part of the offset delta
   logic [5:0] coarse_mod [16];
   for (genvar k = 0; k < 16; k++) begin : g_coarse
      localparam int CM = ((k - 8) % GEAR_TURNS + GEAR_TURNS) % GEAR_TURNS;
      assign coarse_mod[k] = CM[5:0];
   end

   logic        ref_taken_ff, ref_taken_in;
   logic [9:0]  ref_offset_ff, ref_offset_in;
   logic [15:0] prev_rotor_ff, prev_rotor_in;
   logic [5:0]  turn_ff, turn_in;
   logic [15:0] counter_ff [NUM_TARGETS];
   logic [15:0] counter_in;
   logic [IDX_W-1:0] cnt_idx;
   logic        cnt_wr;

   stage_type   a_ff, a_in;
   logic        a_valid_ff, a_valid_in;
   rsp_type     o_ff, o_in;
   logic        o_valid_ff, o_valid_in;
   logic        adv_a;

   logic [15:0]        rotor;
   logic [15:0]        prev_eff;
   logic [9:0]         ref_eff;
   logic signed [16:0] delta;
   logic signed [10:0] off_delta;
   logic [5:0]         turn_new;
   logic [6:0]         turn_sum;
   logic [18:0]        scaled;
   logic [SHIFT+18:0]  product;

   assign adv_a  = !o_valid_ff || rsp_pop;
   assign q_read = !q_empty && (!a_valid_ff || adv_a);

   // Stage A: counters, feeder turn tracking, field unpack
   always_comb begin
      rotor     = q_job.payload[63:48];
      prev_eff  = ref_taken_ff ? prev_rotor_ff : rotor;
      ref_eff   = ref_taken_ff ? ref_offset_ff : rotor[15:6];
      delta     = signed'({1'b0, rotor}) - signed'({1'b0, prev_eff});
      off_delta = signed'({1'b0, rotor[15:6]}) - signed'({1'b0, ref_eff});
      if (delta > WRAP_LIMIT) begin
         turn_new = (turn_ff == '0) ? LAST_TURN : turn_ff - 6'd1;
      end else if (delta < -WRAP_LIMIT) begin
         turn_new = (turn_ff >= LAST_TURN) ? 6'd0 : turn_ff + 6'd1;
      end else begin
         turn_new = turn_ff;
      end
      turn_sum = {1'b0, turn_new} + {1'b0, coarse_mod[{~off_delta[10], off_delta[9:7]}]};
      if (turn_sum >= GEAR_C) begin
         turn_sum = turn_sum - GEAR_C;
      end

      cnt_idx    = IDX_W'(q_job.target - 3'd1);
      counter_in = counter_ff[cnt_idx] + 16'd1;
      cnt_wr     = 1'b0;

      ref_taken_in  = ref_taken_ff;
      ref_offset_in = ref_offset_ff;
      prev_rotor_in = prev_rotor_ff;
      turn_in       = turn_ff;

      a_in = '0;
      a_in.target = q_job.target;
      unique case (q_job.target)
         TGT_NONE: begin
         end
         TGT_CHASSIS: begin
            cnt_wr            = 1'b1;
            a_in.frame_count  = counter_in;
            a_in.status_bytes = q_job.payload[63:24];
         end
         TGT_FRICTION_A, TGT_FRICTION_B, TGT_FEEDER, TGT_PITCH, TGT_YAW: begin
            cnt_wr              = 1'b1;
            a_in.frame_count    = counter_in;
            a_in.rotor_position = rotor;
            a_in.speed          = q_job.payload[47:32];
            a_in.torque_current = q_job.payload[31:16];
            a_in.temperature    = q_job.payload[15:8];
            if (q_job.target == TGT_FEEDER) begin
               a_in.feeder   = 1'b1;
               a_in.turn_mod = turn_sum[5:0];
               a_in.fine     = off_delta[6:0];
               ref_taken_in  = 1'b1;
               ref_offset_in = ref_eff;
               prev_rotor_in = rotor;
               turn_in       = turn_new;
            end
         end
         default: begin
            a_in.target = TGT_NONE;
         end
      endcase

      a_valid_in = q_read || (a_valid_ff && !adv_a);
   end

   // Stage B: shaft angle = floor(x * 64 / GEAR_TURNS) by reciprocal multiply
   always_comb begin
      scaled  = {a_ff.turn_mod, a_ff.fine, 6'd0};
      product = scaled * RECIP_C;
      o_in.target         = a_ff.target;
      o_in.rotor_position = a_ff.rotor_position;
      o_in.speed          = a_ff.speed;
      o_in.torque_current = a_ff.torque_current;
      o_in.temperature    = a_ff.temperature;
      o_in.shaft_position = a_ff.feeder ? product[SHIFT+12:SHIFT] : 13'd0;
      o_in.status_bytes   = a_ff.status_bytes;
      o_in.frame_count    = a_ff.frame_count;
      o_valid_in = (a_valid_ff && adv_a) || (o_valid_ff && !rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_taken_ff  <= 1'b0;
         ref_offset_ff <= '0;
         prev_rotor_ff <= '0;
         turn_ff       <= '0;
         for (int i = 0; i < NUM_TARGETS; i++) begin
            counter_ff[i] <= '0;
         end
         a_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (q_read) begin
            ref_taken_ff  <= ref_taken_in;
            ref_offset_ff <= ref_offset_in;
            prev_rotor_ff <= prev_rotor_in;
            turn_ff       <= turn_in;
            if (cnt_wr) begin
               counter_ff[cnt_idx] <= counter_in;
            end
         end
         a_valid_ff <= a_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_read) begin
         a_ff <= a_in;
      end
      if (a_valid_ff && adv_a) begin
         o_ff <= o_in;
      end
   end

   assign rsp_empty = !o_valid_ff;
   assign rsp_data  = o_ff;

`ifndef SYNTH
   a_shaft_only_feeder: assert property (@(posedge clock) disable iff (reset)
      o_valid_ff && (o_ff.shaft_position != '0) |-> (o_ff.target == TGT_FEEDER))
      else $error("shaft angle on non-feeder result");
   a_turn_in_range: assert property (@(posedge clock) disable iff (reset)
      q_read && (q_job.target == TGT_FEEDER) |=> (turn_ff <= LAST_TURN))
      else $error("turn count out of range");
   a_ref_sticky: assert property (@(posedge clock) disable iff (reset)
      $past(ref_taken_ff) |-> ref_taken_ff)
      else $error("reference lost");
`endif

endmodule

// ===== tb/sv/tb_can_motor_feedback_decoder.sv =====
`timescale 1ns / 100ps

module tb_can_motor_feedback_decoder;
   import cmfd_pkg::*;

   localparam int GEAR_TURNS   = 36;
   localparam int STEP_PER_REV = 128;        // shaft steps per rotor turn
   localparam int HOLD_CYCLES  = 200;        // long receiver hold-off
   localparam int SETTLE       = 10;         // allow margin for stray results
   localparam int RANDOM_ITEMS = 630;        // per idling phase

   logic    clock;
   logic    reset;
   logic    req_push = 1'b0;
   logic    req_full;
   req_type req_data = '0;
   logic    rsp_empty;
   logic    rsp_pop  = 1'b0;
   rsp_type rsp_data;

   can_motor_feedback_decoder #(.GEAR_TURNS(GEAR_TURNS)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   // Stimulus and scoreboard storage
   req_type frames_to_send[$];     // filled by the sequence, drained by the driver
   rsp_type due_feedback[$];       // predicted decodes, oldest first

   // Shadow of the block's state, advanced as each request is accepted
   bit          ref_taken;
   logic [9:0]  ref_offset;
   logic [15:0] prev_rotor;
   logic [5:0]  turn_count;
   logic [15:0] frame_counter[NUM_TARGETS];

   // Idling control; the percentages and the hold request are set at the falling edge
   int send_idle_pct = 30;
   int take_idle_pct = 58;
   bit hold_go       = 1'b0;
   int hold_left     = 0;

   int mismatches = 0;

   // Feeder rotor walk used by the random sequence
   logic [15:0] feeder_rotor = 16'h0;
   int          spin         = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // Generous fixed time limit on the whole run
   initial begin
      #10_000_000;
      $display("status: fail");
      $finish;
   end

   // ------------------------------------------------------------------
   // Predictor: route, bump the counter, unpack, track feeder turns
   // ------------------------------------------------------------------
   function automatic rsp_type decode_frame(req_type f);
      rsp_type    r;
      target_type t;
      logic [15:0] rotor;
      int count;
      int delta;
      int x;
      int modulus;

      r = '0;
      t = TGT_NONE;
      modulus = GEAR_TURNS * STEP_PER_REV;
      if (f.bus == BUS_FIRST) begin
         case (f.frame_id)
            ID_FRICTION_A: t = TGT_FRICTION_A;
            ID_FRICTION_B: t = TGT_FRICTION_B;
            ID_FEEDER:     t = TGT_FEEDER;
            ID_PITCH:      t = TGT_PITCH;
            default:       t = TGT_NONE;
         endcase
      end else begin
         case (f.frame_id)
            ID_YAW:     t = TGT_YAW;
            ID_CHASSIS: t = TGT_CHASSIS;
            default:    t = TGT_NONE;
         endcase
      end
      // unrouted frames leave everything untouched and report all zeros
      if (t == TGT_NONE)
         return r;

      frame_counter[int'(t) - 1] = frame_counter[int'(t) - 1] + 16'd1;
      r.target      = t;
      r.frame_count = frame_counter[int'(t) - 1];

      if (t == TGT_CHASSIS) begin
         r.status_bytes = f.payload[63:24];
         return r;
      end

      r.rotor_position = f.payload[63:48];
      r.speed          = f.payload[47:32];
      r.torque_current = f.payload[31:16];
      r.temperature    = f.payload[15:8];

      if (t == TGT_FEEDER) begin
         rotor = f.payload[63:48];
         // first feeder frame fixes the zero of the output shaft
         if (!ref_taken) begin
            ref_taken  = 1'b1;
            ref_offset = rotor[15:6];
            prev_rotor = rotor;
         end
         count = int'(turn_count) % GEAR_TURNS;
         delta = int'(rotor) - int'(prev_rotor);
         // a jump up means the rotor wrapped backwards, a jump down forwards
         if (delta > WRAP_LIMIT)
            count = (count == 0) ? GEAR_TURNS - 1 : count - 1;
         else if (-delta > WRAP_LIMIT)
            count = (count >= GEAR_TURNS - 1) ? 0 : count + 1;
         turn_count = count[5:0];

         x = count * STEP_PER_REV + int'(rotor[15:6]) - int'(ref_offset);
         x = x % modulus;
         if (x < 0)
            x = x + modulus;
         r.shaft_position = 13'((x * 64) / GEAR_TURNS);
         prev_rotor = rotor;
      end
      return r;
   endfunction

   function automatic string fmt_feedback(rsp_type r);
      return $sformatf("tgt=%0d pos=%h spd=%h cur=%h tmp=%h shaft=%0d stat=%h cnt=%0d",
                       r.target, r.rotor_position, r.speed, r.torque_current,
                       r.temperature, r.shaft_position, r.status_bytes, r.frame_count);
   endfunction

   // ------------------------------------------------------------------
   // Driver: offers the next pending frame, holds it while full
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full)
            due_feedback.push_back(decode_frame(req_data));
         // slot is free unless a request is still waiting on full
         if (!req_push || !req_full) begin
            if (frames_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_data <= frames_to_send.pop_front();
               req_push <= 1'b1;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, counted here so the driver keeps going
   always @(posedge clock) begin
      if (hold_go) begin
         hold_left <= HOLD_CYCLES;
         hold_go   <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // ------------------------------------------------------------------
   // Monitor: checks each popped result against the oldest prediction
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (due_feedback.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: %s", fmt_feedback(rsp_data));
            end else begin
               want = due_feedback.pop_front();
               if (rsp_data.target         !== want.target         ||
                   rsp_data.rotor_position !== want.rotor_position ||
                   rsp_data.speed          !== want.speed          ||
                   rsp_data.torque_current !== want.torque_current ||
                   rsp_data.temperature    !== want.temperature    ||
                   rsp_data.shaft_position !== want.shaft_position ||
                   rsp_data.status_bytes   !== want.status_bytes   ||
                   rsp_data.frame_count    !== want.frame_count) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch at %0t", $realtime);
                     $display("  expected %s", fmt_feedback(want));
                     $display("  actual   %s", fmt_feedback(rsp_data));
                  end
               end
            end
         end
         rsp_pop <= (hold_left == 0) && ($urandom_range(0, 99) >= take_idle_pct);
      end
   end

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   function automatic req_type make_frame(logic bus, logic [10:0] id, logic [63:0] data);
      req_type f;
      f.bus      = bus;
      f.frame_id = id;
      f.payload  = data;
      return f;
   endfunction

   function automatic logic [63:0] rand_payload();
      return {$urandom, $urandom};
   endfunction

   function automatic req_type feeder_frame(logic [15:0] rotor);
      logic [63:0] d;
      d = rand_payload();
      return make_frame(BUS_FIRST, ID_FEEDER, {rotor, d[47:0]});
   endfunction

   // wait until every frame is sent and every predicted result has been popped
   task automatic wait_drained();
      do @(negedge clock);
      while (frames_to_send.size() != 0 || req_push || due_feedback.size() != 0);
   endtask

   task automatic queue_directed();
      // each route, with field extremes
      frames_to_send.push_back(make_frame(BUS_FIRST, ID_FRICTION_A, '1));
      frames_to_send.push_back(make_frame(BUS_FIRST, ID_FRICTION_B, '0));
      frames_to_send.push_back(make_frame(BUS_FIRST, ID_PITCH, 64'h0000_8000_7FFF_FF00));
      frames_to_send.push_back(make_frame(~BUS_FIRST, ID_YAW, 64'hFFFF_7FFF_8000_00FF));
      frames_to_send.push_back(make_frame(~BUS_FIRST, ID_CHASSIS, '1));
      frames_to_send.push_back(make_frame(~BUS_FIRST, ID_CHASSIS, 64'h0123_4567_89AB_CDEF));
      // known identifiers on the wrong bus, and identifier extremes
      frames_to_send.push_back(make_frame(~BUS_FIRST, ID_FRICTION_A, '1));
      frames_to_send.push_back(make_frame(~BUS_FIRST, ID_FEEDER, '1));
      frames_to_send.push_back(make_frame(BUS_FIRST, ID_CHASSIS, '1));
      frames_to_send.push_back(make_frame(BUS_FIRST, ID_YAW, '1));
      frames_to_send.push_back(make_frame(BUS_FIRST, 11'h000, '1));
      frames_to_send.push_back(make_frame(~BUS_FIRST, 11'h7FF, '1));
      // feeder: reference on first frame, then a jump of exactly the limit
      // (no wrap), just over it (backwards wrap from 0) and back (forwards
      // wrap from the top), then the rotor extremes
      frames_to_send.push_back(feeder_frame(16'd4096));
      frames_to_send.push_back(feeder_frame(16'd8192));
      frames_to_send.push_back(feeder_frame(16'd12289));
      frames_to_send.push_back(feeder_frame(16'd8192));
      frames_to_send.push_back(feeder_frame(16'hFFFF));
      frames_to_send.push_back(feeder_frame(16'h0000));
      frames_to_send.push_back(feeder_frame(16'hFFFF));
      frames_to_send.push_back(feeder_frame(16'd4160));
   endtask

   task automatic queue_random(int n);
      int kind;
      int step;
      logic [63:0] d;
      for (int i = 0; i < n; i++) begin
         kind = $urandom_range(0, 99);
         d    = rand_payload();
         if (kind < 35) begin
            // feeder walk: mostly small moves, spells of spinning one way
            // so the turn count crosses its wrap in both directions
            if ($urandom_range(0, 99) < 3)
               spin = int'($urandom_range(0, 2)) - 1;
            case ($urandom_range(0, 9))
               0:       feeder_rotor = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
               1:       feeder_rotor = 16'($urandom);
               default: begin
                  if (spin != 0)
                     step = spin * int'($urandom_range(4097, 12000));
                  else
                     step = int'($urandom_range(0, 9000)) - 4500;
                  feeder_rotor = feeder_rotor + 16'(step);
               end
            endcase
            frames_to_send.push_back(make_frame(BUS_FIRST, ID_FEEDER,
                                                {feeder_rotor, d[47:0]}));
         end else if (kind < 75) begin
            case ($urandom_range(0, 4))
               0: frames_to_send.push_back(make_frame(BUS_FIRST, ID_FRICTION_A, d));
               1: frames_to_send.push_back(make_frame(BUS_FIRST, ID_FRICTION_B, d));
               2: frames_to_send.push_back(make_frame(BUS_FIRST, ID_PITCH, d));
               3: frames_to_send.push_back(make_frame(~BUS_FIRST, ID_YAW, d));
               default: frames_to_send.push_back(make_frame(~BUS_FIRST, ID_CHASSIS, d));
            endcase
         end else if (kind < 88) begin
            // valid identifier, wrong bus
            case ($urandom_range(0, 5))
               0: frames_to_send.push_back(make_frame(~BUS_FIRST, ID_FRICTION_A, d));
               1: frames_to_send.push_back(make_frame(~BUS_FIRST, ID_FRICTION_B, d));
               2: frames_to_send.push_back(make_frame(~BUS_FIRST, ID_FEEDER, d));
               3: frames_to_send.push_back(make_frame(~BUS_FIRST, ID_PITCH, d));
               4: frames_to_send.push_back(make_frame(BUS_FIRST, ID_YAW, d));
               default: frames_to_send.push_back(make_frame(BUS_FIRST, ID_CHASSIS, d));
            endcase
         end else begin
            frames_to_send.push_back(make_frame(1'($urandom), 11'($urandom), d));
         end
      end
   endtask

   initial begin
      ref_taken  = 1'b0;
      ref_offset = '0;
      prev_rotor = '0;
      turn_count = '0;
      foreach (frame_counter[i])
         frame_counter[i] = '0;

      @(negedge clock);
      while (reset)
         @(negedge clock);

      // directed frames, sender idles 30 %, receiver 58 %
      queue_directed();
      wait_drained();

      // random, same idling; receiver holds off first so the queue fills
      hold_go = 1'b1;
      queue_random(RANDOM_ITEMS);
      wait_drained();

      // random, idling swapped
      send_idle_pct = 58;
      take_idle_pct = 30;
      queue_random(RANDOM_ITEMS);
      wait_drained();

      // random at full rate
      send_idle_pct = 0;
      take_idle_pct = 0;
      queue_random(RANDOM_ITEMS);
      wait_drained();

      // catch any stray result after the last one expected
      repeat (SETTLE) @(negedge clock);
      if (due_feedback.size() != 0)
         mismatches++;

      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
